[rtl/core/olid_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_pkg: shared types and codes for the ordered list block
// Request and response words, operation codes, status codes and the
// per-cell update codes.
// ----------------------------------------------------------------------------
package olid_pkg;

	localparam int FIELD_W = 32;

	typedef struct packed {
		logic [2:0]                mode;
		logic signed [FIELD_W-1:0] value;
		logic signed [FIELD_W-1:0] key;
	} req_word_t;

	typedef struct packed {
		logic [1:0]                status;
		logic signed [FIELD_W-1:0] item_value;
		logic [4:0]                length;
		logic                      last;
	} rsp_word_t;

	localparam logic [2:0] MODE_INS_FRONT = 3'd0;
	localparam logic [2:0] MODE_INS_AFTER = 3'd1;
	localparam logic [2:0] MODE_INS_END   = 3'd2;
	localparam logic [2:0] MODE_DEL_FRONT = 3'd3;
	localparam logic [2:0] MODE_DEL_KEY   = 3'd4;
	localparam logic [2:0] MODE_DEL_END   = 3'd5;
	localparam logic [2:0] MODE_DUMP      = 3'd6;

	localparam logic [1:0] STAT_DONE      = 2'd0;
	localparam logic [1:0] STAT_NOT_FOUND = 2'd1;
	localparam logic [1:0] STAT_EMPTY     = 2'd2;
	localparam logic [1:0] STAT_FULL      = 2'd3;

	typedef logic [2:0] cell_op_t;

	localparam cell_op_t CELL_HOLD  = 3'd0;
	localparam cell_op_t CELL_LOAD  = 3'd1;
	localparam cell_op_t CELL_LEFT  = 3'd2;
	localparam cell_op_t CELL_RIGHT = 3'd3;
	localparam cell_op_t CELL_HEAD  = 3'd4;

endpackage

[rtl/core/olid_cell.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_cell: one list slot
// Holds one word, compares it against the search key and takes its next
// word from the new value, a neighbor, or the head slot.
// ----------------------------------------------------------------------------
module olid_cell #(
	parameter int WORD_WIDTH = 32
) (
	input  logic                  clk,
	input  olid_pkg::cell_op_t    op,
	input  logic [WORD_WIDTH-1:0] left_word,
	input  logic [WORD_WIDTH-1:0] right_word,
	input  logic [WORD_WIDTH-1:0] head_word,
	input  logic [WORD_WIDTH-1:0] load_word,
	input  logic [WORD_WIDTH-1:0] key,
	output logic [WORD_WIDTH-1:0] word,
	output logic                  match
);
	import olid_pkg::*;

	logic [WORD_WIDTH-1:0] word_q;

	always_ff @(posedge clk) begin
		case (op)
			CELL_HOLD:  word_q <= word_q;
			CELL_LOAD:  word_q <= load_word;
			CELL_LEFT:  word_q <= left_word;
			CELL_RIGHT: word_q <= right_word;
			CELL_HEAD:  word_q <= head_word;
			default:    word_q <= word_q;
		endcase
	end

	assign word  = word_q;
	assign match = (word_q == key);

endmodule

[rtl/core/ordered_list_insert_delete.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ordered_list_insert_delete: bounded ordered list of signed words
// Row of slot cells with parallel key compare and shift insert/delete.
// ----------------------------------------------------------------------------
// An insert or delete spans the cycle the request word is accepted, in which
// every cell compares its word against the key and the match flags are
// registered, and the apply state, in which the first match is picked and the
// whole row shifts at once. A dump goes on from the apply state to the dump
// state, where the row rotates one slot a cycle while the response is not
// stalled and the head slot is reported each time, so the list is back in
// place when the dump ends. A stalled response holds the state. A new request
// may be accepted while the last response word still waits in the output register.
module ordered_list_insert_delete #(
	parameter int CAPACITY   = 16,
	parameter int WORD_WIDTH = 32
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_stall,
	input  olid_pkg::req_word_t req,
	output logic                rsp_valid,
	input  logic                rsp_stall,
	output olid_pkg::rsp_word_t rsp
);
	import olid_pkg::*;

	localparam int CW = $clog2(CAPACITY + 1);

	localparam logic [1:0] ST_IDLE  = 2'd0;
	localparam logic [1:0] ST_APPLY = 2'd1;
	localparam logic [1:0] ST_DUMP  = 2'd2;

	logic [1:0]            state_q, state_n;
	logic [CW-1:0]         count_q, count_n;
	logic [CW-1:0]         dcnt_q;
	logic [2:0]            mode_q;
	logic [WORD_WIDTH-1:0] value_q;
	logic [CAPACITY-1:0]   match_q;
	logic                  rsp_valid_q;
	rsp_word_t             rsp_q;

	logic [WORD_WIDTH-1:0] words [CAPACITY];
	logic [CAPACITY-1:0]   match_c;
	cell_op_t              ops [CAPACITY];

	logic [63:0]           value_z, key_z;
	logic [WORD_WIDTH-1:0] key_w;
	logic                  accept, out_free;
	logic [CW-1:0]         cnt_m1;
	logic [CAPACITY:0]     cnt_oh, tail_oh, valid_mask, below_tail;
	logic [CAPACITY-1:0]   first, pos, ge;
	logic                  full, empty, found;
	logic                  emit;
	logic [1:0]            status_c;
	logic [WORD_WIDTH-1:0] item_c, removed;
	logic                  last_c;
	logic [CW+4:0]         len_z;

	function automatic logic [FIELD_W-1:0] report(input logic [WORD_WIDTH-1:0] w);
		logic signed [63:0] ext;
		ext = 64'(signed'(w));
		return ext[FIELD_W-1:0];
	endfunction

	assign value_z = {32'b0, req.value};
	assign key_z   = {32'b0, req.key};
	assign key_w   = key_z[WORD_WIDTH-1:0];

	assign accept    = req_valid && !req_stall;
	assign req_stall = (state_q != ST_IDLE);
	assign out_free  = !rsp_valid_q || !rsp_stall;

	assign cnt_m1     = count_q - 1'b1;
	assign cnt_oh     = (CAPACITY + 1)'(1) << count_q;
	assign tail_oh    = (CAPACITY + 1)'(1) << cnt_m1;
	assign valid_mask = cnt_oh - 1'b1;
	assign below_tail = tail_oh - 1'b1;

	assign full  = (count_q == CW'(CAPACITY));
	assign empty = (count_q == '0);
	assign found = |match_q;
	assign first = match_q & (~match_q + 1'b1);

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [WORD_WIDTH-1:0] left_w, right_w;
		if (i == 0) begin : g_head
			assign left_w = '0;
		end else begin : g_mid
			assign left_w = words[i-1];
		end
		if (i == CAPACITY - 1) begin : g_tail
			assign right_w = '0;
		end else begin : g_body
			assign right_w = words[i+1];
		end
		olid_cell #(.WORD_WIDTH(WORD_WIDTH)) u_cell (
			.clk        (clk),
			.op         (ops[i]),
			.left_word  (left_w),
			.right_word (right_w),
			.head_word  (words[0]),
			.load_word  (value_q),
			.key        (key_w),
			.word       (words[i]),
			.match      (match_c[i])
		);
	end

	// pick the slot the operation works on, as a one-hot vector
	always_comb begin
		case (mode_q)
			MODE_INS_FRONT, MODE_DEL_FRONT: pos = CAPACITY'(1);
			MODE_INS_AFTER: pos = {first[CAPACITY-2:0], 1'b0};
			MODE_INS_END:   pos = cnt_oh[CAPACITY-1:0];
			MODE_DEL_KEY:   pos = first;
			MODE_DEL_END:   pos = tail_oh[CAPACITY-1:0];
			default:        pos = '0;
		endcase
	end

	assign ge = ~(pos - 1'b1);

	always_comb begin
		removed = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			removed = removed | (words[i] & {WORD_WIDTH{pos[i]}});
		end
	end

	always_comb begin
		state_n  = state_q;
		count_n  = count_q;
		emit     = 1'b0;
		status_c = STAT_DONE;
		item_c   = '0;
		last_c   = 1'b1;
		for (int i = 0; i < CAPACITY; i++) begin
			ops[i] = CELL_HOLD;
		end
		case (state_q)
			ST_IDLE: begin
				if (req_valid) begin
					state_n = ST_APPLY;
				end
			end
			ST_APPLY: begin
				if (mode_q == MODE_DUMP && !empty) begin
					state_n = ST_DUMP;
				end else if (out_free) begin
					emit    = 1'b1;
					state_n = ST_IDLE;
					case (mode_q)
						MODE_INS_FRONT, MODE_INS_AFTER, MODE_INS_END: begin
							if (full) begin
								status_c = STAT_FULL;
							end else if (mode_q == MODE_INS_AFTER && !found) begin
								status_c = STAT_NOT_FOUND;
							end else begin
								count_n = count_q + 1'b1;
								for (int i = 0; i < CAPACITY; i++) begin
									if (pos[i]) ops[i] = CELL_LOAD;
									else if (ge[i]) ops[i] = CELL_LEFT;
								end
							end
						end
						MODE_DEL_FRONT, MODE_DEL_KEY, MODE_DEL_END: begin
							if (empty) begin
								status_c = STAT_EMPTY;
							end else if (mode_q == MODE_DEL_KEY && !found) begin
								status_c = STAT_NOT_FOUND;
							end else begin
								count_n = count_q - 1'b1;
								item_c  = removed;
								for (int i = 0; i < CAPACITY; i++) begin
									if (ge[i]) ops[i] = CELL_RIGHT;
								end
							end
						end
						MODE_DUMP: status_c = STAT_EMPTY;
						default:   status_c = STAT_DONE;
					endcase
				end
			end
			ST_DUMP: begin
				if (out_free) begin
					emit   = 1'b1;
					item_c = words[0];
					last_c = (dcnt_q == cnt_m1);
					// rotate the held entries: head wraps to the tail slot
					for (int i = 0; i < CAPACITY; i++) begin
						if (below_tail[i]) ops[i] = CELL_RIGHT;
						else if (tail_oh[i]) ops[i] = CELL_HEAD;
					end
					if (last_c) begin
						state_n = ST_IDLE;
					end
				end
			end
			default: state_n = ST_IDLE;
		endcase
	end

	assign len_z = {5'b0, count_n};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			count_q     <= '0;
			dcnt_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_n;
			count_q <= count_n;
			if (state_q == ST_APPLY) begin
				dcnt_q <= '0;
			end else if (state_q == ST_DUMP && out_free) begin
				dcnt_q <= dcnt_q + 1'b1;
			end
			if (emit) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			mode_q  <= req.mode;
			value_q <= value_z[WORD_WIDTH-1:0];
			match_q <= match_c & valid_mask[CAPACITY-1:0];
		end
		if (emit) begin
			rsp_q.status     <= status_c;
			rsp_q.item_value <= report(item_c);
			rsp_q.length     <= len_z[4:0];
			rsp_q.last       <= last_c;
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

endmodule

[rtl/core/olid_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// olid_checker: port-level checks for the ordered list block
// Watches the request and response channels and the response codes.
// ----------------------------------------------------------------------------
module olid_checker #(
	parameter int CAPACITY = 16
) (
	input logic                clk,
	input logic                arst_n,
	input logic                req_valid,
	input logic                req_stall,
	input olid_pkg::req_word_t req,
	input logic                rsp_valid,
	input logic                rsp_stall,
	input olid_pkg::rsp_word_t rsp
);
	import olid_pkg::*;

	localparam logic [4:0] CAP_LEN = 5'(CAPACITY);

	// a stalled response word holds
	a_rsp_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
		else $error("response word changed while stalled");

	// an accepted request keeps the block busy for the next cycle
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && !req_stall |=> req_stall)
		else $error("request taken back to back");

	a_full: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_FULL |->
		rsp.length == CAP_LEN && rsp.item_value == '0 && rsp.last)
		else $error("bad full response");

	a_empty: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && rsp.status == STAT_EMPTY |->
		rsp.length == '0 && rsp.item_value == '0 && rsp.last)
		else $error("bad empty response");

endmodule

bind ordered_list_insert_delete olid_checker #(.CAPACITY(CAPACITY)) u_olid_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.req       (req),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall),
	.rsp       (rsp)
);
